>>> src/cui_pkg.sv
// ----------------------------------------------------------------------------
// cui_pkg
// Shared constants, tap codes and coefficient functions for the chroma
// upsampling interpolator.
// ----------------------------------------------------------------------------
package cui_pkg;

   localparam int CUI_SAMPLE_BITS  = 17;
   // headroom for weights up to 8 plus the rounding constant
   localparam int CUI_GUARD_BITS   = 4;
   localparam int CUI_FACTOR_BITS  = 3;
   localparam int CUI_PHASE_BITS   = 2;
   localparam int CUI_TAP_BITS     = 3;
   localparam int CUI_SHIFT_BITS   = 2;
   localparam int CUI_CSR_IDX_BITS = 1;
   localparam int CUI_CSR_DATA_BITS = CUI_FACTOR_BITS;

   // configuration register indexes
   localparam logic [CUI_CSR_IDX_BITS-1:0] CSR_HORIZ_FACTOR = 1'd0;
   localparam logic [CUI_CSR_IDX_BITS-1:0] CSR_VERT_FACTOR  = 1'd1;

   localparam logic [CUI_FACTOR_BITS-1:0] FACTOR_RESET = 3'd1;

   // filter tap codes
   localparam logic [CUI_TAP_BITS-1:0] TAP_PASS    = 3'd0; // copy the center sample
   localparam logic [CUI_TAP_BITS-1:0] TAP_QTR_PRV = 3'd1; // 1/4, 3/4 toward previous
   localparam logic [CUI_TAP_BITS-1:0] TAP_QTR_NXT = 3'd2; // 1/4, 3/4 toward next
   localparam logic [CUI_TAP_BITS-1:0] TAP_EIG_P0  = 3'd3; // 3/8, 5/8 previous
   localparam logic [CUI_TAP_BITS-1:0] TAP_EIG_P1  = 3'd4; // 1/8, 7/8 previous
   localparam logic [CUI_TAP_BITS-1:0] TAP_EIG_P2  = 3'd5; // 1/8, 7/8 next
   localparam logic [CUI_TAP_BITS-1:0] TAP_EIG_P3  = 3'd6; // 3/8, 5/8 next

   typedef struct packed {
      logic                      valid;
      logic [CUI_SHIFT_BITS-1:0] v_shift;
      logic [CUI_TAP_BITS-1:0]   h_tap;
   } cui_s1_ctl_type;

   typedef struct packed {
      logic                      valid;
      logic [CUI_SHIFT_BITS-1:0] h_shift;
   } cui_s2_ctl_type;

   function automatic logic [CUI_FACTOR_BITS-1:0] clamp_factor(
      input logic [CUI_FACTOR_BITS-1:0] f);
      logic [CUI_FACTOR_BITS-1:0] r;
      if (f == 3'd0) begin
         r = 3'd1;
      end else if (f > 3'd4) begin
         r = 3'd4;
      end else begin
         r = f;
      end
      return r;
   endfunction

   function automatic logic [CUI_TAP_BITS-1:0] tap_decode(
      input logic [CUI_FACTOR_BITS-1:0] raw_factor,
      input logic [CUI_PHASE_BITS-1:0]  raw_phase);
      logic [CUI_FACTOR_BITS-1:0] f;
      logic [CUI_PHASE_BITS-1:0]  ph;
      logic [CUI_TAP_BITS-1:0]    tap;
      f  = clamp_factor(raw_factor);
      // a phase at or above the factor acts as phase 0
      ph = ({1'b0, raw_phase} >= f) ? 2'd0 : raw_phase;
      case (f)
         3'd2: begin
            tap = (ph == 2'd0) ? TAP_QTR_PRV : TAP_QTR_NXT;
         end
         3'd3: begin
            case (ph)
               2'd0:    tap = TAP_QTR_PRV;
               2'd1:    tap = TAP_PASS;
               default: tap = TAP_QTR_NXT;
            endcase
         end
         3'd4: begin
            case (ph)
               2'd0:    tap = TAP_EIG_P0;
               2'd1:    tap = TAP_EIG_P1;
               2'd2:    tap = TAP_EIG_P2;
               default: tap = TAP_EIG_P3;
            endcase
         end
         default: tap = TAP_PASS;
      endcase
      return tap;
   endfunction

   function automatic logic [1:0] tap_w_side(input logic [CUI_TAP_BITS-1:0] tap);
      logic [1:0] w;
      case (tap)
         TAP_QTR_PRV, TAP_QTR_NXT, TAP_EIG_P1, TAP_EIG_P2: w = 2'd1;
         TAP_EIG_P0, TAP_EIG_P3:                           w = 2'd3;
         default:                                          w = 2'd0;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] tap_w_mid(input logic [CUI_TAP_BITS-1:0] tap);
      logic [2:0] w;
      case (tap)
         TAP_QTR_PRV, TAP_QTR_NXT: w = 3'd3;
         TAP_EIG_P0, TAP_EIG_P3:   w = 3'd5;
         TAP_EIG_P1, TAP_EIG_P2:   w = 3'd7;
         default:                  w = 3'd1;
      endcase
      return w;
   endfunction

   function automatic logic tap_use_next(input logic [CUI_TAP_BITS-1:0] tap);
      return (tap == TAP_QTR_NXT) || (tap == TAP_EIG_P2) || (tap == TAP_EIG_P3);
   endfunction

   function automatic logic [CUI_SHIFT_BITS-1:0] tap_shift(
      input logic [CUI_TAP_BITS-1:0] tap);
      logic [CUI_SHIFT_BITS-1:0] s;
      case (tap)
         TAP_QTR_PRV, TAP_QTR_NXT:                         s = 2'd2;
         TAP_EIG_P0, TAP_EIG_P1, TAP_EIG_P2, TAP_EIG_P3:  s = 2'd3;
         default:                                          s = 2'd0;
      endcase
      return s;
   endfunction

   // vertical rounding depends on the parity of the column
   function automatic logic [2:0] vert_round(input logic [CUI_TAP_BITS-1:0] tap,
                                             input logic odd);
      logic [2:0] r;
      case (tap)
         TAP_QTR_PRV:                        r = odd ? 3'd1 : 3'd2;
         TAP_QTR_NXT:                        r = odd ? 3'd2 : 3'd1;
         TAP_EIG_P1:                         r = odd ? 3'd4 : 3'd3;
         TAP_EIG_P0, TAP_EIG_P2, TAP_EIG_P3: r = odd ? 3'd3 : 3'd4;
         default:                            r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] horiz_round(input logic [CUI_TAP_BITS-1:0] tap);
      logic [2:0] r;
      case (tap)
         TAP_QTR_PRV, TAP_EIG_P0, TAP_EIG_P2: r = 3'd2;
         TAP_QTR_NXT, TAP_EIG_P1, TAP_EIG_P3: r = 3'd1;
         default:                             r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/cui_if.sv
// ----------------------------------------------------------------------------
// cui_if
// Request and response channel interfaces of the chroma upsampling
// interpolator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cui_req_if import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) ();
   logic                            valid;
   logic                            ready;
   logic signed [SAMPLE_BITS-1:0]   above_left;
   logic signed [SAMPLE_BITS-1:0]   above_mid;
   logic signed [SAMPLE_BITS-1:0]   above_right;
   logic signed [SAMPLE_BITS-1:0]   here_left;
   logic signed [SAMPLE_BITS-1:0]   here_mid;
   logic signed [SAMPLE_BITS-1:0]   here_right;
   logic signed [SAMPLE_BITS-1:0]   below_left;
   logic signed [SAMPLE_BITS-1:0]   below_mid;
   logic signed [SAMPLE_BITS-1:0]   below_right;
   logic [CUI_PHASE_BITS-1:0]       h_phase;
   logic [CUI_PHASE_BITS-1:0]       v_phase;
   logic                            col_parity;

   modport source (
      output valid, above_left, above_mid, above_right, here_left, here_mid,
             here_right, below_left, below_mid, below_right, h_phase, v_phase,
             col_parity,
      input  ready
   );
   modport sink (
      input  valid, above_left, above_mid, above_right, here_left, here_mid,
             here_right, below_left, below_mid, below_right, h_phase, v_phase,
             col_parity,
      output ready
   );
endinterface

interface cui_rsp_if import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] upsampled_sample;

   modport source (output valid, upsampled_sample, input ready);
   modport sink   (input valid, upsampled_sample, output ready);
endinterface

>>> src/chroma_upsample_interpolator_top.sv
// path: an accepted item passes the vertical stage, the horizontal stage and the output register
// throughput: one item per cycle; ready falls only when all three stages hold
// items and the response side stalls
// reset: synchronous, clears every stage valid and sets both factors to 1
// ----------------------------------------------------------------------------
// chroma_upsample_interpolator_top
// Triangle-filter chroma upsampler, factors 1 to 4 each way: vertical sums,
// horizontal sum, then the output register.
// ----------------------------------------------------------------------------
module chroma_upsample_interpolator_top import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   cui_req_if.sink                        req,
   cui_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [CUI_CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CUI_CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SUM_BITS = SAMPLE_BITS + CUI_GUARD_BITS;

   logic [CUI_FACTOR_BITS-1:0]  horiz_factor_ff, horiz_factor_in;
   logic [CUI_FACTOR_BITS-1:0]  vert_factor_ff, vert_factor_in;

   cui_s1_ctl_type              s1_ctl;
   cui_s2_ctl_type              s2_ctl;
   logic                        s2_ready, s3_ready;
   logic signed [SUM_BITS-1:0]  left_sum, mid_sum, right_sum, horiz_sum;
   logic signed [SUM_BITS-1:0]  shifted;

   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;

   // configuration registers
   always_comb begin
      horiz_factor_in = horiz_factor_ff;
      vert_factor_in  = vert_factor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HORIZ_FACTOR: horiz_factor_in = csr_wdata;
            CSR_VERT_FACTOR:  vert_factor_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_factor_ff <= FACTOR_RESET;
         vert_factor_ff  <= FACTOR_RESET;
      end else begin
         horiz_factor_ff <= horiz_factor_in;
         vert_factor_ff  <= vert_factor_in;
      end
   end

   cui_vert_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_vert (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .above_left   (req.above_left),
      .above_mid    (req.above_mid),
      .above_right  (req.above_right),
      .here_left    (req.here_left),
      .here_mid     (req.here_mid),
      .here_right   (req.here_right),
      .below_left   (req.below_left),
      .below_mid    (req.below_mid),
      .below_right  (req.below_right),
      .h_phase      (req.h_phase),
      .v_phase      (req.v_phase),
      .col_parity   (req.col_parity),
      .horiz_factor (horiz_factor_ff),
      .vert_factor  (vert_factor_ff),
      .out_ctl      (s1_ctl),
      .out_ready    (s2_ready),
      .left_sum     (left_sum),
      .mid_sum      (mid_sum),
      .right_sum    (right_sum)
   );

   cui_horiz_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_horiz (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s1_ctl),
      .in_ready  (s2_ready),
      .left_sum  (left_sum),
      .mid_sum   (mid_sum),
      .right_sum (right_sum),
      .out_ctl   (s2_ctl),
      .out_ready (s3_ready),
      .horiz_sum (horiz_sum)
   );

   // output stage: final floor shift into the response register
   assign s3_ready = !out_valid_ff || rsp.ready;

   always_comb begin
      case (s2_ctl.h_shift)
         2'd2:    shifted = horiz_sum >>> 2;
         2'd3:    shifted = horiz_sum >>> 3;
         default: shifted = horiz_sum;
      endcase
      out_sample_in = shifted[SAMPLE_BITS-1:0];
      out_valid_in  = s3_ready ? s2_ctl.valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_ctl.valid) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.upsampled_sample = out_sample_ff;

endmodule

>>> src/cui_vert_stage.sv
// ----------------------------------------------------------------------------
// cui_vert_stage
// First pipeline stage: decodes factors and phases, forms the weighted
// vertical sums of the left, center and right columns.
// ----------------------------------------------------------------------------
module cui_vert_stage import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0]                 above_left,
   input  logic signed [SAMPLE_BITS-1:0]                 above_mid,
   input  logic signed [SAMPLE_BITS-1:0]                 above_right,
   input  logic signed [SAMPLE_BITS-1:0]                 here_left,
   input  logic signed [SAMPLE_BITS-1:0]                 here_mid,
   input  logic signed [SAMPLE_BITS-1:0]                 here_right,
   input  logic signed [SAMPLE_BITS-1:0]                 below_left,
   input  logic signed [SAMPLE_BITS-1:0]                 below_mid,
   input  logic signed [SAMPLE_BITS-1:0]                 below_right,
   input  logic [CUI_PHASE_BITS-1:0]                     h_phase,
   input  logic [CUI_PHASE_BITS-1:0]                     v_phase,
   input  logic                                          col_parity,
   input  logic [CUI_FACTOR_BITS-1:0]                    horiz_factor,
   input  logic [CUI_FACTOR_BITS-1:0]                    vert_factor,
   output cui_s1_ctl_type                                out_ctl,
   input  logic                                          out_ready,
   output logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  left_sum,
   output logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  mid_sum,
   output logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  right_sum
);

   localparam int SUM_BITS = SAMPLE_BITS + CUI_GUARD_BITS;

   function automatic logic signed [SUM_BITS-1:0] col_sum(
      input logic signed [SAMPLE_BITS-1:0] t,
      input logic signed [SAMPLE_BITS-1:0] c,
      input logic signed [SAMPLE_BITS-1:0] b,
      input logic [CUI_TAP_BITS-1:0]       tap,
      input logic                          odd);
      logic signed [SUM_BITS-1:0] side_x;
      logic signed [SUM_BITS-1:0] mid_x;
      logic signed [SUM_BITS-1:0] ws_x;
      logic signed [SUM_BITS-1:0] wm_x;
      logic signed [SUM_BITS-1:0] rnd_x;
      side_x = tap_use_next(tap) ? SUM_BITS'(b) : SUM_BITS'(t);
      mid_x  = SUM_BITS'(c);
      ws_x   = SUM_BITS'(tap_w_side(tap));
      wm_x   = SUM_BITS'(tap_w_mid(tap));
      rnd_x  = SUM_BITS'(vert_round(tap, odd));
      return side_x * ws_x + mid_x * wm_x + rnd_x;
   endfunction

   logic                          valid_ff, valid_in;
   logic [CUI_SHIFT_BITS-1:0]     v_shift_ff, v_shift_in;
   logic [CUI_TAP_BITS-1:0]       h_tap_ff, h_tap_in;
   logic [CUI_TAP_BITS-1:0]       v_tap;
   logic signed [SUM_BITS-1:0]    lsum_ff, lsum_in;
   logic signed [SUM_BITS-1:0]    msum_ff, msum_in;
   logic signed [SUM_BITS-1:0]    rsum_ff, rsum_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      v_tap      = tap_decode(vert_factor, v_phase);
      v_shift_in = tap_shift(v_tap);
      h_tap_in   = tap_decode(horiz_factor, h_phase);
      // side columns carry the opposite parity of the center one
      lsum_in    = col_sum(above_left, here_left, below_left, v_tap, !col_parity);
      msum_in    = col_sum(above_mid, here_mid, below_mid, v_tap, col_parity);
      rsum_in    = col_sum(above_right, here_right, below_right, v_tap, !col_parity);
      valid_in   = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         v_shift_ff <= v_shift_in;
         h_tap_ff   <= h_tap_in;
         lsum_ff    <= lsum_in;
         msum_ff    <= msum_in;
         rsum_ff    <= rsum_in;
      end
   end

   assign out_ctl.valid   = valid_ff;
   assign out_ctl.v_shift = v_shift_ff;
   assign out_ctl.h_tap   = h_tap_ff;
   assign left_sum        = lsum_ff;
   assign mid_sum         = msum_ff;
   assign right_sum       = rsum_ff;

endmodule

>>> src/cui_horiz_stage.sv
// ----------------------------------------------------------------------------
// cui_horiz_stage
// Second pipeline stage: floors the vertical sums into column results and
// forms the weighted horizontal sum.
// ----------------------------------------------------------------------------
module cui_horiz_stage import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  cui_s1_ctl_type                                in_ctl,
   output logic                                          in_ready,
   input  logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  left_sum,
   input  logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  mid_sum,
   input  logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  right_sum,
   output cui_s2_ctl_type                                out_ctl,
   input  logic                                          out_ready,
   output logic signed [SAMPLE_BITS+CUI_GUARD_BITS-1:0]  horiz_sum
);

   localparam int SUM_BITS = SAMPLE_BITS + CUI_GUARD_BITS;

   // floor shift, the result always fits the sample width
   function automatic logic signed [SAMPLE_BITS-1:0] floor_shift(
      input logic signed [SUM_BITS-1:0]  sum,
      input logic [CUI_SHIFT_BITS-1:0]   sh);
      logic signed [SUM_BITS-1:0] s;
      case (sh)
         2'd2:    s = sum >>> 2;
         2'd3:    s = sum >>> 3;
         default: s = sum;
      endcase
      return s[SAMPLE_BITS-1:0];
   endfunction

   logic                          valid_ff, valid_in;
   logic [CUI_SHIFT_BITS-1:0]     h_shift_ff, h_shift_in;
   logic signed [SUM_BITS-1:0]    hsum_ff, hsum_in;
   logic signed [SAMPLE_BITS-1:0] col_l, col_c, col_r;
   logic signed [SUM_BITS-1:0]    side_x, mid_x, ws_x, wm_x, rnd_x;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      col_l      = floor_shift(left_sum, in_ctl.v_shift);
      col_c      = floor_shift(mid_sum, in_ctl.v_shift);
      col_r      = floor_shift(right_sum, in_ctl.v_shift);
      side_x     = tap_use_next(in_ctl.h_tap) ? SUM_BITS'(col_r) : SUM_BITS'(col_l);
      mid_x      = SUM_BITS'(col_c);
      ws_x       = SUM_BITS'(tap_w_side(in_ctl.h_tap));
      wm_x       = SUM_BITS'(tap_w_mid(in_ctl.h_tap));
      rnd_x      = SUM_BITS'(horiz_round(in_ctl.h_tap));
      hsum_in    = side_x * ws_x + mid_x * wm_x + rnd_x;
      h_shift_in = tap_shift(in_ctl.h_tap);
      valid_in   = in_ready ? in_ctl.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         h_shift_ff <= h_shift_in;
         hsum_ff    <= hsum_in;
      end
   end

   assign out_ctl.valid   = valid_ff;
   assign out_ctl.h_shift = h_shift_ff;
   assign horiz_sum       = hsum_ff;

endmodule

>>> src/cui_checker.sv
// ----------------------------------------------------------------------------
// cui_checker
// Port-level checks of the chroma upsampling interpolator, bound to the top.
// ----------------------------------------------------------------------------
module cui_checker import cui_pkg::*; #(
   parameter int SAMPLE_BITS = CUI_SAMPLE_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // a waiting item stays on the port
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample))
      else $error("response item changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the response side open, an accepted item passes both stages and the output register to the port
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_acc, 3) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1)
      && $past(rsp_ready, 2) && $past(rsp_ready, 1) |-> rsp_valid)
      else $error("item not delivered after three open cycles");

endmodule

bind chroma_upsample_interpolator_top cui_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cui_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_sample (rsp.upsampled_sample)
);
